/* hw/rtl/tcfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_pkg: shared types and constants of the crossfade envelope core
// Holds the word layouts, the command codes and the channel state record.
// ----------------------------------------------------------------------------
package tcfe_pkg;

  localparam int unsigned NumChan  = 2;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned CntW     = 3;
  localparam int unsigned VolW     = 16;
  localparam int unsigned RateW    = 17;
  localparam int unsigned IdW      = 8;
  localparam int unsigned DtW      = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  localparam logic [VolW-1:0] VolFull = 16'd32768;

  typedef enum logic [1:0] {
    CMD_SET_VOLUME = 2'd0,
    CMD_STOP       = 2'd1,
    CMD_PLAY       = 2'd2
  } cmd_e;

  typedef struct packed {
    logic            mode;
    logic [DtW-1:0]  tick_time;
    logic            has_sound;
    logic [IdW-1:0]  sound_id;
    logic [VolW-1:0] target_volume;
  } item_t;

  typedef struct packed {
    cmd_e            command;
    logic            channel;
    logic [VolW-1:0] volume;
    logic [IdW-1:0]  play_id;
    logic            last;
  } result_t;

  typedef struct packed {
    logic                            active;
    logic [NumChan-1:0]              busy;
    logic [NumChan-1:0][IdW-1:0]     sound;
    logic [NumChan-1:0][VolW-1:0]    volume;
    logic [NumChan-1:0][VolW-1:0]    target;
    logic [NumChan-1:0][RateW-1:0]   rate;
  } chan_state_t;

endpackage

/* hw/rtl/tcfe_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfe_update: next-state and command logic for one word
// Works out the new channel state and the ordered list of mixer commands.
// ----------------------------------------------------------------------------
module tcfe_update import tcfe_pkg::*; (
  input  chan_state_t            state_i,
  input  item_t                  item_i,
  input  logic                   sound_enable_i,
  output chan_state_t            state_o,
  output result_t [MaxRes-1:0]   res_o,
  output logic [CntW-1:0]        count_o
);

  logic [VolW-1:0]                 tv;
  logic                            act;
  logic                            nxt;
  logic                            same;
  logic [VolW-1:0]                 cur_vol;
  logic [VolW-1:0]                 vol_gap;
  logic [18:0]                     vol5;
  logic [NumChan-1:0][33:0]        prod;
  logic [NumChan-1:0][17:0]        step;
  logic [NumChan-1:0][VolW-1:0]    new_vol;
  result_t [MaxRes-1:0]            cand;
  logic [MaxRes-1:0]               cand_v;
  result_t [MaxRes-1:0]            res;
  logic [CntW-1:0]                 k;

  assign tv      = (item_i.target_volume > VolFull) ? VolFull : item_i.target_volume;
  assign act     = state_i.active;
  assign nxt     = ~state_i.active;
  assign cur_vol = state_i.volume[act];
  assign same    = item_i.has_sound && state_i.busy[act] && (state_i.sound[act] == item_i.sound_id);
  assign vol_gap = (tv > cur_vol) ? (tv - cur_vol) : (cur_vol - tv);
  assign vol5    = {1'b0, cur_vol, 2'b00} + 19'(cur_vol);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c] = 34'(state_i.rate[c]) * 34'(item_i.tick_time) + 34'd32768;
      step[c] = prod[c][33:16];
      new_vol[c] = state_i.volume[c];
      if (state_i.volume[c] < state_i.target[c]) begin
        if (step[c] >= 18'(state_i.target[c] - state_i.volume[c])) begin
          new_vol[c] = state_i.target[c];
        end else begin
          new_vol[c] = state_i.volume[c] + step[c][VolW-1:0];
        end
      end else if (state_i.volume[c] > state_i.target[c]) begin
        if (step[c] >= 18'(state_i.volume[c] - state_i.target[c])) begin
          new_vol[c] = state_i.target[c];
        end else begin
          new_vol[c] = state_i.volume[c] - step[c][VolW-1:0];
        end
      end
    end
  end

  always_comb begin
    state_o = state_i;
    cand    = '0;
    cand_v  = '0;
    for (int i = 0; i < MaxRes; i++) begin
      cand[i].command = CMD_SET_VOLUME;
    end
    if (!item_i.mode) begin
      for (int c = 0; c < NumChan; c++) begin
        if (state_i.busy[c]) begin
          state_o.volume[c]     = new_vol[c];
          cand_v[2*c]           = 1'b1;
          cand[2*c].command     = CMD_SET_VOLUME;
          cand[2*c].channel     = 1'(c);
          cand[2*c].volume      = sound_enable_i ? new_vol[c] : '0;
          if ((new_vol[c] == '0) && (state_i.target[c] == '0)) begin
            cand_v[2*c+1]       = 1'b1;
            cand[2*c+1].command = CMD_STOP;
            cand[2*c+1].channel = 1'(c);
            state_o.busy[c]     = 1'b0;
          end
        end
      end
    end else if (same) begin
      state_o.target[act] = tv;
      state_o.rate[act]   = RateW'((18'(vol_gap) + 18'd1) >> 1);
    end else begin
      if (state_i.busy[act]) begin
        state_o.target[act] = '0;
        state_o.rate[act]   = RateW'((vol5 + 19'd1) >> 1);
      end
      if (state_i.busy[nxt]) begin
        cand_v[0]           = 1'b1;
        cand[0].command     = CMD_STOP;
        cand[0].channel     = nxt;
        state_o.busy[nxt]   = 1'b0;
        state_o.volume[nxt] = '0;
      end
      state_o.active = nxt;
      if (item_i.has_sound) begin
        state_o.busy[nxt]   = 1'b1;
        state_o.sound[nxt]  = item_i.sound_id;
        state_o.volume[nxt] = '0;
        state_o.target[nxt] = tv;
        state_o.rate[nxt]   = RateW'((18'(tv) + 18'd1) >> 1);
        cand_v[1]           = 1'b1;
        cand[1].command     = CMD_PLAY;
        cand[1].channel     = nxt;
        cand[1].play_id     = item_i.sound_id;
      end
    end
  end

  always_comb begin
    res = cand;
    k   = '0;
    for (int i = 0; i < MaxRes; i++) begin
      if (cand_v[i]) begin
        res[k[1:0]] = cand[i];
        k = k + 3'd1;
      end
    end
    if (k != '0) begin
      res[2'(k - 3'd1)].last = 1'b1;
    end
  end

  assign res_o   = res;
  assign count_o = k;

endmodule

/* hw/rtl/two_channel_crossfade_envelope_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_crossfade_envelope_core: two-channel crossfade controller
// Ticks and scene changes update two mixer channels and emit mixer commands.
// ----------------------------------------------------------------------------
// A word is registered on input, and its commands are loaded into the command
// queue when the queue is empty or is handing over its last command.
// Throughput: one word per cycle while each word causes at most one command and
// m_tready is high; more commands (at most four) hold the queue until taken.
// Reset clears all channel state and the active channel and sets sound enable.
// ----------------------------------------------------------------------------
module two_channel_crossfade_envelope_core import tcfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,   // sound_enable
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [InDataW-1:0]  s_tdata_i,     // tick_time, has_sound, sound_id, target_volume
  input  logic                s_tuser_i,     // mode
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,     // channel, volume, play_id
  output logic [1:0]          m_tuser_o,     // command
  output logic                m_tlast_o
);

  logic                  enable_q;
  logic                  in_valid_q;
  item_t                 in_q;
  chan_state_t           state_q, state_d;
  result_t [MaxRes-1:0]  queue_q, queue_d;
  result_t [MaxRes-1:0]  new_res;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       new_cnt;
  logic                  out_fire;
  logic                  advance;
  logic                  in_fire;

  assign out_fire   = m_tvalid_o && m_tready_i;
  assign advance    = in_valid_q && ((cnt_q == '0) || ((cnt_q == 3'd1) && out_fire));
  assign s_tready_o = !in_valid_q || advance;
  assign in_fire    = s_tvalid_i && s_tready_o;

  tcfe_update u_update (
    .state_i        (state_q),
    .item_i         (in_q),
    .sound_enable_i (enable_q),
    .state_o        (state_d),
    .res_o          (new_res),
    .count_o        (new_cnt)
  );

  always_comb begin
    queue_d = queue_q;
    cnt_d   = cnt_q;
    if (advance) begin
      queue_d = new_res;
      cnt_d   = new_cnt;
    end else if (out_fire) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        queue_d[i] = queue_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      in_valid_q <= 1'b0;
      state_q    <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.mode          <= s_tuser_i;
      in_q.tick_time     <= s_tdata_i[15:0];
      in_q.has_sound     <= s_tdata_i[16];
      in_q.sound_id      <= s_tdata_i[24:17];
      in_q.target_volume <= s_tdata_i[40:25];
    end
    queue_q <= queue_d;
  end

  assign m_tvalid_o = (cnt_q != '0);
  assign m_tuser_o  = queue_q[0].command;
  assign m_tlast_o  = queue_q[0].last;
  assign m_tdata_o  = {7'd0, queue_q[0].play_id, queue_q[0].volume, queue_q[0].channel};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-channel crossfade envelope core
// Ticks and scene changes go in over the slave stream and mixer commands are
// checked on the master stream against a behavioral model of both channels,
// in order and field by field. Both streams idle at random, and the sound
// enable register is written between phases while the core is quiet.
// ----------------------------------------------------------------------------
module testbench;
  import tcfe_pkg::*;

  localparam logic ModeTick  = 1'b0;
  localparam logic ModeScene = 1'b1;
  localparam int unsigned PlanLen       = 24;
  localparam int unsigned PhaseWords    = 66;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 8;

  typedef struct packed {
    logic            mode;
    logic [DtW-1:0]  dt;
    logic            has;
    logic [IdW-1:0]  id;
    logic [VolW-1:0] tv;
    logic            fixed;
    logic [2:0]      fx_n;
    cmd_e            fx_cmd;
    logic            fx_ch;
    logic [VolW-1:0] fx_vol;
    logic [IdW-1:0]  fx_id;
  } plan_row_t;

  logic                clk_i;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_wdata;
  logic                s_tvalid;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid_o;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata_o;
  logic [1:0]          m_tuser_o;
  logic                m_tlast_o;

  // Model of the mixer channels.
  logic                  mix_enable;
  logic                  lead_ch;
  logic [NumChan-1:0]    ch_busy;
  logic [IdW-1:0]        ch_sound [NumChan];
  logic [VolW-1:0]       ch_vol   [NumChan];
  logic [VolW-1:0]       ch_tgt   [NumChan];
  logic [RateW-1:0]      ch_rate  [NumChan];

  result_t     cmd_batch [$];
  result_t     pending_cmds [$];
  plan_row_t   plan [PlanLen];
  int unsigned n_words;
  int unsigned n_cmds;
  int unsigned n_errors;
  int unsigned idle_count;
  int unsigned rx_hold;
  logic        rx_calm;
  logic        tx_calm;

  two_channel_crossfade_envelope_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (n_errors < 40) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    n_errors++;
  endtask

  task automatic check_word(input string where, input result_t got, input result_t want);
    if (got.command !== want.command) begin
      report_mismatch($sformatf("%s command %0d, want %0d", where, got.command, want.command));
    end
    if (got.channel !== want.channel) begin
      report_mismatch($sformatf("%s channel %0d, want %0d", where, got.channel, want.channel));
    end
    if (got.volume !== want.volume) begin
      report_mismatch($sformatf("%s volume %0d, want %0d", where, got.volume, want.volume));
    end
    if (got.play_id !== want.play_id) begin
      report_mismatch($sformatf("%s play_id %0d, want %0d", where, got.play_id, want.play_id));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("%s last %0d, want %0d", where, got.last, want.last));
    end
  endtask

  function automatic void emit_cmd(input cmd_e cmd, input logic ch, input logic [VolW-1:0] vol,
                                   input logic [IdW-1:0] id);
    result_t r;
    r.command = cmd;
    r.channel = ch;
    r.volume  = vol;
    r.play_id = id;
    r.last    = 1'b0;
    cmd_batch.push_back(r);
  endfunction

  function automatic void ramp_channel(input logic ch, input logic [DtW-1:0] dt);
    logic [33:0]     prod;
    logic [17:0]     step;
    logic [VolW-1:0] v;
    logic [VolW-1:0] t;
    if (!ch_busy[ch]) return;
    v = ch_vol[ch];
    t = ch_tgt[ch];
    prod = 34'(ch_rate[ch]) * 34'(dt) + 34'd32768;
    step = prod[33:16];
    if (v < t) begin
      v = (step >= 18'(t - v)) ? t : v + step[15:0];
    end else if (v > t) begin
      v = (step >= 18'(v - t)) ? t : v - step[15:0];
    end
    ch_vol[ch] = v;
    emit_cmd(CMD_SET_VOLUME, ch, mix_enable ? v : '0, '0);
    if (v == '0 && t == '0) begin
      emit_cmd(CMD_STOP, ch, '0, '0);
      ch_busy[ch] = 1'b0;
    end
  endfunction

  function automatic void advance_mixer(input item_t it);
    logic [VolW-1:0] tv;
    logic [VolW-1:0] d;
    logic            a;
    logic            n;
    cmd_batch.delete();
    tv = (it.target_volume > VolFull) ? VolFull : it.target_volume;
    a = lead_ch;
    n = ~lead_ch;
    if (it.mode == ModeTick) begin
      ramp_channel(1'b0, it.tick_time);
      ramp_channel(1'b1, it.tick_time);
    end else if (it.has_sound && ch_busy[a] && ch_sound[a] == it.sound_id) begin
      d = (tv > ch_vol[a]) ? tv - ch_vol[a] : ch_vol[a] - tv;
      ch_tgt[a]  = tv;
      ch_rate[a] = RateW'((18'(d) + 18'd1) >> 1);
    end else begin
      if (ch_busy[a]) begin
        ch_tgt[a]  = '0;
        ch_rate[a] = RateW'((20'(ch_vol[a]) * 20'd5 + 20'd1) >> 1);
      end
      if (ch_busy[n]) begin
        emit_cmd(CMD_STOP, n, '0, '0);
        ch_busy[n] = 1'b0;
        ch_vol[n]  = '0;
      end
      lead_ch = n;
      if (it.has_sound) begin
        ch_busy[n]  = 1'b1;
        ch_sound[n] = it.sound_id;
        ch_vol[n]   = '0;
        ch_tgt[n]   = tv;
        ch_rate[n]  = RateW'((18'(tv) + 18'd1) >> 1);
        emit_cmd(CMD_PLAY, n, '0, it.sound_id);
      end
    end
    if (cmd_batch.size() > 0) cmd_batch[cmd_batch.size()-1].last = 1'b1;
  endfunction

  function automatic plan_row_t mk(input logic mode, input logic [DtW-1:0] dt, input logic has,
                                   input logic [IdW-1:0] id, input logic [VolW-1:0] tv,
                                   input logic fixed, input logic [2:0] n, input cmd_e c,
                                   input logic ch, input logic [VolW-1:0] vol,
                                   input logic [IdW-1:0] pid);
    plan_row_t r;
    r = '{mode, dt, has, id, tv, fixed, n, c, ch, vol, pid};
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VolW-1:0] random_level();
    if ($urandom_range(0, 9) == 0) return VolW'($urandom_range(0, 65535));
    return VolW'($urandom_range(0, 32768));
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned r;
    int unsigned k;
    it.tick_time     = DtW'($urandom);
    it.has_sound     = 1'($urandom);
    it.sound_id      = IdW'($urandom);
    it.target_volume = VolW'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      it.mode = ModeTick;
      k = $urandom_range(0, 9);
      if (k < 7) it.tick_time = DtW'($urandom_range(0, 20000));
      else if (k == 8) it.tick_time = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      it.mode = ModeScene;
      if (r < 75) begin
        it.has_sound     = 1'b1;
        it.sound_id      = ch_sound[lead_ch];
        it.target_volume = random_level();
      end else if (r < 95) begin
        it.has_sound     = 1'b1;
        it.target_volume = random_level();
      end else begin
        it.has_sound = 1'b0;
      end
    end
    return it;
  endfunction

  task automatic hold_off(input int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_word(input item_t it);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {7'd0, it.target_volume, it.sound_id, it.has_sound, it.tick_time};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    advance_mixer(it);
    n_words++;
  endtask

  task automatic settle();
    hold_off(1);
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    mix_enable = v;
  endtask

  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      rx_hold  <= idle_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_n && m_tvalid_o && m_tready) begin
      got.command = cmd_e'(m_tuser_o);
      got.channel = m_tdata_o[0];
      got.volume  = m_tdata_o[16:1];
      got.play_id = m_tdata_o[24:17];
      got.last    = m_tlast_o;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command word %0d", n_cmds));
      end else begin
        check_word($sformatf("word %0d", n_cmds), got, pending_cmds.pop_front());
      end
      n_cmds++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) begin
      idle_count <= 0;
    end else if (idle_count == WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    item_t       it;
    result_t     typed;
    int unsigned counted;
    logic        phase_en [NumPhases];

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    rx_hold   = 0;
    rx_calm   = 1'b0;
    tx_calm   = 1'b0;
    n_words   = 0;
    n_cmds    = 0;
    n_errors  = 0;
    idle_count = 0;

    mix_enable = 1'b1;
    lead_ch  = 1'b0;
    ch_busy  = '0;
    for (int c = 0; c < NumChan; c++) begin
      ch_sound[c] = '0;
      ch_vol[c]   = '0;
      ch_tgt[c]   = '0;
      ch_rate[c]  = '0;
    end

    plan[0]  = mk(ModeScene, 16'd0,     1'b1, 8'd5,   16'd40000, 1'b1, 3'd1, CMD_PLAY, 1'b1, '0, 8'd5);
    plan[1]  = mk(ModeTick,  16'd0,     1'b0, 8'd0,   16'd0,     1'b1, 3'd1, CMD_SET_VOLUME, 1'b1, '0,
                  8'd0);
    plan[2]  = mk(ModeTick,  16'hFFFF,  1'b1, 8'hFF,  16'hFFFF,  1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[3]  = mk(ModeTick,  16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[4]  = mk(ModeTick,  16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[5]  = mk(ModeScene, 16'd0,     1'b1, 8'd5,   16'd0,     1'b1, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[6]  = mk(ModeTick,  16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[7]  = mk(ModeScene, 16'd0,     1'b1, 8'd9,   16'd32768, 1'b1, 3'd1, CMD_PLAY, 1'b0, '0, 8'd9);
    plan[8]  = mk(ModeTick,  16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[9]  = mk(ModeScene, 16'd0,     1'b1, 8'd200, 16'd32768, 1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[10] = mk(ModeScene, 16'd0,     1'b1, 8'd201, 16'd32768, 1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[11] = mk(ModeScene, 16'd0,     1'b1, 8'd201, 16'd0,     1'b1, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[12] = mk(ModeTick,  16'd1,     1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[13] = mk(ModeTick,  16'hFFFF,  1'b1, 8'hFF,  16'hFFFF,  1'b1, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[14] = mk(ModeScene, 16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b1, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[15] = mk(ModeScene, 16'd0,     1'b1, 8'hFF,  16'hFFFF,  1'b1, 3'd1, CMD_PLAY, 1'b0, '0, 8'hFF);
    plan[16] = mk(ModeTick,  16'h8000,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[17] = mk(ModeScene, 16'd0,     1'b1, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[18] = mk(ModeTick,  16'h4000,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[19] = mk(ModeScene, 16'd0,     1'b0, 8'hAA,  16'h5555,  1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[20] = mk(ModeTick,  16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[21] = mk(ModeScene, 16'd0,     1'b1, 8'h5A,  16'h4000,  1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[22] = mk(ModeTick,  16'hFFFF,  1'b0, 8'd0,   16'd0,     1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);
    plan[23] = mk(ModeScene, 16'd0,     1'b0, 8'h55,  16'hAAAA,  1'b0, 3'd0, CMD_STOP, 1'b0, '0, '0);

    phase_en[0] = 1'b0;
    phase_en[1] = 1'b1;
    phase_en[2] = 1'b1;
    phase_en[3] = 1'b0;
    phase_en[4] = 1'b1;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    write_enable(1'b1);
    for (int i = 0; i < PlanLen; i++) begin
      it.mode          = plan[i].mode;
      it.tick_time     = plan[i].dt;
      it.has_sound     = plan[i].has;
      it.sound_id      = plan[i].id;
      it.target_volume = plan[i].tv;
      send_word(it);
      if (plan[i].fixed) begin
        typed.command = plan[i].fx_cmd;
        typed.channel = plan[i].fx_ch;
        typed.volume  = plan[i].fx_vol;
        typed.play_id = plan[i].fx_id;
        typed.last    = 1'b1;
        if (cmd_batch.size() != plan[i].fx_n) begin
          report_mismatch($sformatf("row %0d model gives %0d commands", i, cmd_batch.size()));
        end else if (plan[i].fx_n == 1) begin
          check_word($sformatf("row %0d model", i), cmd_batch[0], typed);
        end
        if (plan[i].fx_n == 1) pending_cmds.push_back(typed);
      end else begin
        pending_cmds = {pending_cmds, cmd_batch};
      end
      hold_off(idle_len());
    end
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      write_enable(phase_en[p]);
      counted = 0;
      while (counted < PhaseWords) begin
        if (counted % 24 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        it = random_item();
        if (it.mode == ModeScene || ch_busy != '0) counted++;
        send_word(it);
        pending_cmds = {pending_cmds, cmd_batch};
        if (!tx_calm) hold_off(idle_len());
      end
      settle();
    end
    rx_calm = 1'b0;

    $display("ran %0d stream words and checked %0d mixer commands", n_words, n_cmds);
    $display("covered ticks, retargets, crossfades and silence with sound on and off");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
